[rtl/efs_pkg.sv]
`timescale 1ns / 1ps
package efs_pkg;

  localparam int LEN_W     = 11;
  localparam int TOL_W     = 6;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 16;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT    = 1'b1;

  localparam logic [LEN_W-1:0] BUFLEN_RESET = 11'd1024;
  localparam logic [TOL_W-1:0] TOL_RESET    = 6'd6;
  localparam logic [LEN_W-1:0] MIN_LEN      = 11'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd2;

  localparam logic [IDX_W-1:0] ZERO_FAULT_INDEX = 10'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREV,
    ST_FAULT,
    ST_WALK,
    ST_DONE
  } state_e;

  // Verdict of the compare unit for one walked sample.
  typedef struct packed {
    logic improve;
    logic halt;
  } eval_t;

endpackage

[rtl/efs_if.sv]
`timescale 1ns / 1ps
interface efs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [9:0]  sample_index;
  logic signed [15:0] sample_value;
  logic [9:0]  fault_index;
  logic [9:0]  search_range;

  modport source (output valid, opcode, sample_index, sample_value, fault_index,
                  search_range, input ready);
  modport sink (input valid, opcode, sample_index, sample_value, fault_index,
                search_range, output ready);
endinterface

interface efs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] extreme_index;

  modport source (output valid, status, extreme_index, input ready);
  modport sink (input valid, status, extreme_index, output ready);
endinterface

[rtl/efs_ram.sv]
`timescale 1ns / 1ps
module efs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/efs_eval.sv]
`timescale 1ns / 1ps
module efs_eval #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ext_i,
  input  logic [SAMPLE_WIDTH:0]          jabs_i,
  input  logic                           rising_i,
  input  logic [efs_pkg::TOL_W-1:0]      miss_i,
  input  logic [efs_pkg::TOL_W-1:0]      tol_i,
  output efs_pkg::eval_t                 eval_o
);
  import efs_pkg::*;

  logic signed [SAMPLE_WIDTH+2:0] s2;
  logic signed [SAMPLE_WIDTH+2:0] e2;
  logic signed [SAMPLE_WIDTH+2:0] j3;
  logic [TOL_W:0]                 miss_inc;
  logic                           fell_back;

  // Doubled values keep the half-jump test exact.
  assign s2 = {{2{sample_i[SAMPLE_WIDTH-1]}}, sample_i, 1'b0};
  assign e2 = {{2{ext_i[SAMPLE_WIDTH-1]}}, ext_i, 1'b0};
  assign j3 = $signed({2'b00, jabs_i});

  assign miss_inc  = {1'b0, miss_i} + {{TOL_W{1'b0}}, 1'b1};
  assign fell_back = rising_i ? ((s2 + j3) < e2) : ((s2 - j3) > e2);

  always_comb begin
    eval_o.improve = rising_i ? (sample_i >= ext_i) : (sample_i <= ext_i);
    eval_o.halt    = !eval_o.improve &&
                     ((miss_inc >= {1'b0, tol_i}) || fell_back);
  end

endmodule

[rtl/extreme_after_fault_search.sv]
`timescale 1ns / 1ps
// Extreme-after-fault search over a ring of current samples. A write item
// (opcode 0) stores one signed sample; it gives no result. A search item
// (opcode 1) names a fault position: the block reads the sample before the
// fault and the fault sample, takes the jump direction from their
// difference, and then walks the ring from the position after the fault,
// following the running maximum on a rising jump or the running minimum on a
// falling or zero jump. A search occupies the block while it reads those two
// samples and walks n samples (n at most search_range plus the miss
// tolerance), because the single read port of the sample RAM delivers one
// sample per cycle; a search with fault index zero or beyond the ring skips
// the reads and the walk.
// The result item then sits in an output register, so the next item can be
// accepted while the result waits. Configuration is to be written through the
// cfg_* port only while the block is idle, which the block itself does not
// enforce; buffer_length is clamped into 2..SAMPLE_DEPTH when used. Reading a
// ring entry that was never written gives an undefined result.
module extreme_after_fault_search #(
  parameter int SAMPLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [efs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [efs_pkg::CFG_W-1:0]     cfg_data_i,
  efs_in_if.sink                        in_i,
  efs_out_if.source                     out_o
);
  import efs_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);

  // Configuration registers.
  logic [LEN_W-1:0] buflen_q;
  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buflen_q <= BUFLEN_RESET;
      tol_q    <= TOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BUFFER_LENGTH: buflen_q <= cfg_data_i;
        CFG_MISS_LIMIT:    tol_q    <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective ring length, clamped into the legal range.
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    if (buflen_q < MIN_LEN) begin
      len_eff = MIN_LEN;
    end else if ((SAMPLE_DEPTH < 2048) && (32'(buflen_q) > SAMPLE_DEPTH)) begin
      len_eff = LEN_W'(SAMPLE_DEPTH);
    end else begin
      len_eff = buflen_q;
    end
  end

  state_e state_q, state_d;

  logic [IDX_W-1:0]               fault_q, fault_d;
  logic [LEN_W-1:0]               len_q, len_d;
  logic [LEN_W-1:0]               count_q, count_d;
  logic [LEN_W-1:0]               k_q, k_d;
  logic [LEN_W-1:0]               pos_q, pos_d;
  logic [TOL_W-1:0]               miss_q, miss_d;
  logic signed [SAMPLE_WIDTH-1:0] prev_q, prev_d;
  logic signed [SAMPLE_WIDTH-1:0] ext_q, ext_d;
  logic [SAMPLE_WIDTH:0]          jabs_q, jabs_d;
  logic                           rising_q, rising_d;
  logic [STAT_W-1:0]              status_q, status_d;
  logic [IDX_W-1:0]               idx_q, idx_d;

  logic                           out_valid_q, out_valid_d;
  logic [STAT_W-1:0]              out_status_q, out_status_d;
  logic [IDX_W-1:0]               out_idx_q, out_idx_d;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [SAMPLE_WIDTH-1:0]        mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic [SAMPLE_WIDTH-1:0]        mem_rdata;
  logic signed [SAMPLE_WIDTH-1:0] rd_sample;

  logic                           in_acc;
  logic                           out_free;
  logic                           special;
  logic [LEN_W-1:0]               first_inc, first_pos;
  logic [LEN_W-1:0]               next_inc, next_pos;
  logic [LEN_W-1:0]               k_inc;
  logic signed [SAMPLE_WIDTH:0]   jump;
  logic signed [SAMPLE_WIDTH-1:0] wr_sample;
  eval_t                          ev;

  assign rd_sample = $signed(mem_rdata);
  assign wr_sample = SAMPLE_WIDTH'($unsigned(in_i.sample_value));

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.extreme_index = out_idx_q;

  // Fault index zero and a fault beyond the ring are answered without a walk.
  assign special = (in_i.fault_index == '0) || ({1'b0, in_i.fault_index} >= len_eff);

  // Ring successors with wrap at the effective length.
  assign first_inc = {1'b0, fault_q} + LEN_W'(1);
  assign first_pos = (first_inc >= len_q) ? '0 : first_inc;
  assign next_inc  = pos_q + LEN_W'(1);
  assign next_pos  = (next_inc >= len_q) ? '0 : next_inc;
  assign k_inc     = k_q + LEN_W'(1);

  assign jump = $signed({rd_sample[SAMPLE_WIDTH-1], rd_sample}) -
                $signed({prev_q[SAMPLE_WIDTH-1], prev_q});

  efs_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  efs_eval #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_eval (
    .sample_i (rd_sample),
    .ext_i    (ext_q),
    .jabs_i   (jabs_q),
    .rising_i (rising_q),
    .miss_i   (miss_q),
    .tol_i    (tol_q),
    .eval_o   (ev)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.opcode == OP_SEARCH)) begin
          state_d = special ? ST_DONE : ST_PREV;
        end
      end
      ST_PREV:  state_d = ST_FAULT;
      ST_FAULT: state_d = (count_q == '0) ? ST_DONE : ST_WALK;
      ST_WALK: begin
        if (ev.halt || (k_inc == count_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result register.
  always_comb begin
    fault_d      = fault_q;
    len_d        = len_q;
    count_d      = count_q;
    k_d          = k_q;
    pos_d        = pos_q;
    miss_d       = miss_q;
    prev_d       = prev_q;
    ext_d        = ext_q;
    jabs_d       = jabs_q;
    rising_d     = rising_q;
    status_d     = status_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = AW'(in_i.sample_index);
    mem_wdata    = wr_sample;
    mem_raddr    = AW'(in_i.fault_index - IDX_W'(1));

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OP_WRITE) begin
            // Positions beyond the RAM are dropped.
            mem_we = (32'(in_i.sample_index) < SAMPLE_DEPTH);
          end else begin
            fault_d = in_i.fault_index;
            len_d   = len_eff;
            count_d = LEN_W'(in_i.search_range) + LEN_W'(tol_q);
            if (in_i.fault_index == '0) begin
              status_d = STATUS_ZERO;
              idx_d    = ZERO_FAULT_INDEX;
            end else begin
              status_d = STATUS_NONE;
              idx_d    = '0;
            end
          end
        end
      end
      ST_PREV: begin
        prev_d    = rd_sample;
        mem_raddr = AW'(fault_q);
      end
      ST_FAULT: begin
        ext_d     = rd_sample;
        rising_d  = (jump > 0);
        jabs_d    = (jump < 0) ? (SAMPLE_WIDTH + 1)'(-jump) : (SAMPLE_WIDTH + 1)'(jump);
        pos_d     = first_pos;
        k_d       = '0;
        miss_d    = '0;
        mem_raddr = AW'(first_pos);
      end
      ST_WALK: begin
        pos_d     = next_pos;
        k_d       = k_inc;
        mem_raddr = AW'(next_pos);
        if (ev.improve) begin
          ext_d    = rd_sample;
          status_d = STATUS_FOUND;
          idx_d    = pos_q[IDX_W-1:0];
          miss_d   = '0;
        end else begin
          miss_d = miss_q + TOL_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_idx_d    = idx_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fault_q      <= fault_d;
    len_q        <= len_d;
    count_q      <= count_d;
    k_q          <= k_d;
    pos_q        <= pos_d;
    miss_q       <= miss_d;
    prev_q       <= prev_d;
    ext_q        <= ext_d;
    jabs_q       <= jabs_d;
    rising_q     <= rising_d;
    status_q     <= status_d;
    idx_q        <= idx_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
  end

`ifndef NO_ASSERTIONS
  // The walk never runs past its sample budget.
  a_walk_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (k_q < count_q))
    else $error("walk counter beyond sample budget");

  // The walk position always stays inside the ring.
  a_walk_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (pos_q < len_q))
    else $error("walk position outside ring");

  // A run of misses reaching the tolerance must have ended the walk.
  a_miss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((miss_q == '0) || (miss_q < tol_q)))
    else $error("miss run exceeded tolerance");

  // A result is only loaded from the done state into a free output register.
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside done state");
`endif

endmodule

[sim/tb_extreme_after_fault_search.sv]
`timescale 1ns / 1ps
module tb_extreme_after_fault_search;
  import efs_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int QUIET_LIMIT = 20000;
  localparam int STALL_CYCLES = 400;

  // One input item as the sender queues it. Writes and searches share the
  // layout; the fields that an opcode ignores still carry random bits.
  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] sample_index;
    logic [VAL_W-1:0] sample_value;
    logic [IDX_W-1:0] fault_index;
    logic [IDX_W-1:0] search_range;
  } ring_cmd_t;

  // One result item: the verdict of a search.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  position;
  } search_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  efs_in_if  sample_bus ();
  efs_out_if result_bus ();

  extreme_after_fault_search DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (sample_bus),
    .out_o       (result_bus)
  );

  always #2 clk_i = ~clk_i;

  // Items waiting to be offered, and the search verdicts still owed by the
  // block, oldest first.
  ring_cmd_t      pending_cmds[$];
  search_result_t owed_results[$];

  // Our own copy of the block's state: the sample ring and both registers.
  // The ring copy is written only by the monitor, at the moment an item is
  // accepted; the registers only by the stimulus process while the block idles.
  logic signed [VAL_W-1:0] ring_model [RING_DEPTH];
  logic [LEN_W-1:0]        ring_length_cfg;
  logic [TOL_W-1:0]        tolerance_cfg;

  // Which ring entries the stimulus has written so far. A search is only
  // ever issued over entries that are known to hold a sample.
  bit ring_written [RING_DEPTH];

  int queued_cnt;
  int accepted_cnt;
  int mismatch_cnt;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  bit in_taken;
  bit offering;
  bit stall_request;
  bit stall_served;
  int stall_left;
  ring_cmd_t head_cmd;

  // The effective ring size: the register value clamped into 2..depth.
  function automatic int ring_span(input logic [LEN_W-1:0] word);
    if (word < MIN_LEN) return int'(MIN_LEN);
    if (word > RING_DEPTH) return RING_DEPTH;
    return int'(word);
  endfunction

  // Works out the verdict of one search from the ring copy. The direction
  // follows the jump into the fault sample; a zero jump is treated as
  // falling. Ties count as improvements. The walk ends after the tolerance
  // count of misses in a row, or when a miss falls back from the extreme by
  // more than half the jump, tested on doubled values so no rounding occurs.
  function automatic search_result_t locate_extreme(input logic [IDX_W-1:0] fault,
                                                    input logic [IDX_W-1:0] range_base);
    search_result_t verdict;
    int span, steps, f, pos, misses, k, jump, jabs, peak, s, tol;
    bit rising, found, walking;
    span = ring_span(ring_length_cfg);
    tol = int'(tolerance_cfg);
    steps = int'(range_base) + tol;
    f = int'(fault);
    verdict = '0;
    if (f == 0) begin
      verdict.status = STATUS_ZERO;
      verdict.position = ZERO_FAULT_INDEX;
      return verdict;
    end
    if (f >= span) begin
      verdict.status = STATUS_NONE;
      return verdict;
    end
    jump = int'(ring_model[f]) - int'(ring_model[f-1]);
    jabs = (jump < 0) ? -jump : jump;
    rising = (jump > 0);
    peak = int'(ring_model[f]);
    found = 1'b0;
    walking = 1'b1;
    misses = 0;
    pos = f + 1;
    for (k = 0; k < steps && walking; k++) begin
      if (pos >= span) pos = 0;
      s = int'(ring_model[pos]);
      if ((rising && s >= peak) || (!rising && s <= peak)) begin
        peak = s;
        verdict.position = pos[IDX_W-1:0];
        found = 1'b1;
        misses = 0;
      end else begin
        misses++;
        if (misses >= tol) walking = 1'b0;
        else if (rising && (2 * s + jabs < 2 * peak)) walking = 1'b0;
        else if (!rising && (2 * s - jabs > 2 * peak)) walking = 1'b0;
      end
      pos++;
    end
    verdict.status = found ? STATUS_FOUND : STATUS_NONE;
    if (!found) verdict.position = '0;
    return verdict;
  endfunction

  function automatic logic [VAL_W-1:0] clip_sample(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[VAL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Sender. A new item is taken from the queue only once the previous one
  // has been accepted; valid then stays high untouched until the handshake.
  // Before each new item the sender may idle at random.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) offering = 1'b0;
      if (!offering && pending_cmds.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        head_cmd = pending_cmds.pop_front();
        sample_bus.opcode       <= head_cmd.opcode;
        sample_bus.sample_index <= head_cmd.sample_index;
        sample_bus.sample_value <= head_cmd.sample_value;
        sample_bus.fault_index  <= head_cmd.fault_index;
        sample_bus.search_range <= head_cmd.search_range;
        sample_bus.valid        <= 1'b1;
        offering = 1'b1;
      end else if (!offering) begin
        sample_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. Ready drops at random, except for one long hold-off that the
  // stimulus asks for once; the hold-off is counted down here so the sender
  // keeps offering items while the block backs up behind its full output.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_request && !stall_served) begin
        stall_left = STALL_CYCLES;
        stall_served = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. Both handshakes are sampled at the rising edge. A result is
  // checked against the oldest owed verdict; an accepted write updates the
  // ring copy and an accepted search adds its verdict to the owed list.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    search_result_t owed;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d index %0d",
                   $time, result_bus.status, result_bus.extreme_index);
          mismatch_cnt++;
        end else begin
          owed = owed_results.pop_front();
          if (result_bus.status !== owed.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, owed.status, result_bus.status);
            mismatch_cnt++;
          end
          if (result_bus.extreme_index !== owed.position) begin
            $display("%0t: extreme_index mismatch, expected %0d, actual %0d",
                     $time, owed.position, result_bus.extreme_index);
            mismatch_cnt++;
          end
        end
      end
      if (sample_bus.valid && sample_bus.ready) begin
        if (sample_bus.opcode == OP_WRITE)
          ring_model[sample_bus.sample_index] = sample_bus.sample_value;
        else
          owed_results.push_back(locate_extreme(sample_bus.fault_index,
                                                sample_bus.search_range));
        accepted_cnt++;
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
    end
  end

  // Watchdog: a run in which no item moves on either side for too long has
  // hung. The limit is far above the longest walk plus the long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("extreme_after_fault_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic put_sample(input int idx, input logic [VAL_W-1:0] value);
    ring_cmd_t c;
    c.opcode = OP_WRITE;
    c.sample_index = idx[IDX_W-1:0];
    c.sample_value = value;
    c.fault_index = IDX_W'($urandom());
    c.search_range = IDX_W'($urandom());
    pending_cmds.push_back(c);
    ring_written[idx] = 1'b1;
    queued_cnt++;
  endtask

  task automatic put_search(input int fault, input int range_base);
    ring_cmd_t c;
    c.opcode = OP_SEARCH;
    c.sample_index = IDX_W'($urandom());
    c.sample_value = VAL_W'($urandom());
    c.fault_index = fault[IDX_W-1:0];
    c.search_range = range_base[IDX_W-1:0];
    pending_cmds.push_back(c);
    queued_cnt++;
  endtask

  // Every entry a search may touch lies below the effective ring size, so
  // writing the missing ones up to that size keeps all reads defined.
  task automatic fill_ring(input int span);
    for (int i = 0; i < span; i++)
      if (!ring_written[i]) put_sample(i, VAL_W'($urandom()));
  endtask

  // A fault event as a real waveform would show it: a step at the fault, a
  // run that keeps improving (with flat stretches, so ties occur), then a
  // tail that falls back by varying amounts, sometimes past half the step
  // and sometimes not, now and then climbing again. A search at the fault
  // follows.
  task automatic put_fault_event(input int span);
    int f, n, tail, k, dir, base, jump_mag, level, peak, total;
    f = $urandom_range(span - 1, 1);
    dir = $urandom_range(1) ? 1 : -1;
    base = int'($urandom_range(40000)) - 20000;
    jump_mag = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(12000));
    put_sample(f - 1, clip_sample(base));
    level = base + dir * jump_mag;
    put_sample(f, clip_sample(level));
    n = $urandom_range(10);
    tail = $urandom_range(8);
    total = (n + tail > span - 2) ? span - 2 : n + tail;
    peak = level;
    for (k = 0; k < total; k++) begin
      if (k < n) begin
        level = level + dir * (($urandom_range(3) == 0) ? 0 : int'($urandom_range(2000)));
        peak = level;
      end else if ($urandom_range(4) == 0) begin
        level = peak + dir * int'($urandom_range(300));
      end else begin
        level = peak - dir * int'($urandom_range(jump_mag + 100));
      end
      put_sample((f + 1 + k) % span, clip_sample(level));
    end
    if ($urandom_range(19) == 0) put_search(f, $urandom_range(1023));
    else put_search(f, $urandom_range(total + 4));
  endtask

  // A search over whatever the ring holds: mostly inside the ring, some at
  // fault zero, some anywhere (beyond the ring when it is short).
  task automatic put_random_search(input int span);
    int pick, fault;
    pick = $urandom_range(19);
    if (pick < 3) fault = 0;
    else if (pick < 6) fault = $urandom_range(1023);
    else fault = $urandom_range(span - 1, 1);
    if ($urandom_range(9) == 0) put_search(fault, $urandom_range(1023));
    else put_search(fault, $urandom_range(31));
  endtask

  task automatic put_random_mix(input int span, input int target);
    int start, pick;
    start = queued_cnt;
    while (queued_cnt - start < target) begin
      pick = $urandom_range(99);
      if (pick < 55) put_fault_event(span);
      else if (pick < 80) put_sample(int'($urandom_range(1023)), VAL_W'($urandom()));
      else put_random_search(span);
    end
  endtask

  // Waits until every queued item has been accepted and every verdict has
  // arrived, then waits further in case a write is still in the block.
  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || owed_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] word);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    if (idx == CFG_BUFFER_LENGTH) ring_length_cfg = word[LEN_W-1:0];
    else tolerance_cfg = word[TOL_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A new setting of both registers, taken only once the block is idle,
  // together with the idling pattern of both sides for what follows.
  task automatic start_phase(input logic [CFG_W-1:0] len_word,
                             input logic [CFG_W-1:0] tol_word,
                             input int sender_idle, input int receiver_idle);
    wait_until_idle();
    write_register(CFG_BUFFER_LENGTH, len_word);
    write_register(CFG_MISS_LIMIT, tol_word);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    sample_bus.valid        = 1'b0;
    sample_bus.opcode       = OP_WRITE;
    sample_bus.sample_index = '0;
    sample_bus.sample_value = '0;
    sample_bus.fault_index  = '0;
    sample_bus.search_range = '0;
    result_bus.ready        = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_BUFFER_LENGTH;
    cfg_data_i  = '0;
    ring_length_cfg = BUFLEN_RESET;
    tolerance_cfg   = TOL_RESET;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_model[i] = '0;
      ring_written[i] = 1'b0;
    end
    send_idle_pct = 14;
    recv_idle_pct = 63;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part on the smallest ring: a length of one clamps to two, and
    // a tolerance of zero means the first miss ends the walk and only the
    // range sets the walk length.
    start_phase(11'd1, 11'd0, 14, 63);
    put_sample(0, 16'h8000);
    put_sample(1, 16'h7FFF);
    // Rising by the largest step: an empty walk, then a walk whose first
    // sample misses, both without any extreme.
    put_search(1, 0);
    put_search(1, 1023);
    // Fault at zero, and faults beyond the ring.
    put_search(0, 1023);
    put_search(1023, 0);
    put_search(2, 7);
    // A zero step is treated as falling; with equal samples every one ties,
    // so the walk runs the full range around the ring.
    put_sample(0, 16'h7FFF);
    put_search(1, 1023);
    put_sample(1023, 16'h0000);
    put_sample(512, 16'hAAAA);
    // Falling by the largest step, then by one: the next sample is higher
    // and ends the walk with nothing found.
    put_sample(1, 16'h8000);
    put_search(1, 3);
    put_sample(0, 16'h0000);
    put_sample(1, 16'hFFFF);
    put_search(1, 1);
    // Rising by one with a lower sample next: the walk ends with nothing found.
    put_sample(0, 16'hFFFE);
    put_search(1, 2);
    put_random_mix(2, 40);

    // Full ring through an oversized length word, with the largest tolerance.
    start_phase(11'd2047, 11'd63, 14, 63);
    fill_ring(ring_span(ring_length_cfg));
    put_random_mix(RING_DEPTH, 160);

    // The reset values, written back; the receiver holds off for a long
    // stretch at the start so the block backs up and stalls its input.
    start_phase(BUFLEN_RESET, CFG_W'(TOL_RESET), 14, 63);
    stall_request = 1'b1;
    put_random_mix(RING_DEPTH, 120);

    start_phase(11'd17, 11'd1, 63, 14);
    put_random_mix(17, 120);

    start_phase(11'd300, 11'd63, 63, 14);
    put_random_mix(300, 120);

    // A length of zero clamps to two; the tolerance word carries high bits
    // that the register drops.
    start_phase(11'd0, 11'h7C5, 63, 14);
    put_random_mix(2, 40);

    start_phase(11'd513, 11'd3, 0, 0);
    put_random_mix(513, 120);

    start_phase(11'd1000, 11'd12, 0, 0);
    put_random_mix(1000, 120);

    wait_until_idle();
    repeat (40) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("extreme_after_fault_search verification clean");
    end else begin
      $display("extreme_after_fault_search verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/efs_pkg.sv
rtl/efs_if.sv
rtl/efs_ram.sv
rtl/efs_eval.sv
rtl/extreme_after_fault_search.sv
sim/tb_extreme_after_fault_search.sv
